// File: rtl/hse_pkg.sv
// ----------------------------------------------------------------------------
// hse_pkg: shared types and codes for the heap sort engine
// Command codes, datapath op codes, controller/datapath status and the
// result queue entry.
// ----------------------------------------------------------------------------
package hse_pkg;

	// fixed field widths of the stream payload
	localparam int CMD_W     = 2;
	localparam int IDX_W     = 10;
	localparam int DATA_W    = 16;
	localparam int CNT_W     = 11;
	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 16;

	localparam logic [CNT_W-1:0] CNT_RESET = 11'd1024;

	// input commands
	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SORT  = 2'd2;

	// datapath operations issued by the controller
	localparam int OP_W = 5;
	localparam logic [OP_W-1:0] OP_IDLE  = 5'd0;
	localparam logic [OP_W-1:0] OP_WR    = 5'd1;   // host write, push empty result
	localparam logic [OP_W-1:0] OP_NOP   = 5'd2;   // unused command, push empty result
	localparam logic [OP_W-1:0] OP_RD    = 5'd3;   // host read issue
	localparam logic [OP_W-1:0] OP_RDRES = 5'd4;   // push read result
	localparam logic [OP_W-1:0] OP_INIT  = 5'd5;   // load heap bounds
	localparam logic [OP_W-1:0] OP_BEGIN = 5'd6;   // start sift, read node
	localparam logic [OP_W-1:0] OP_LOAD  = 5'd7;   // capture sifted value
	localparam logic [OP_W-1:0] OP_CHK   = 5'd8;   // leaf test, read left child
	localparam logic [OP_W-1:0] OP_CMPL  = 5'd9;   // compare left, read right
	localparam logic [OP_W-1:0] OP_CMPR  = 5'd10;  // compare right
	localparam logic [OP_W-1:0] OP_DEC   = 5'd11;  // move child up or settle
	localparam logic [OP_W-1:0] OP_PDEC  = 5'd12;  // next parent of build phase
	localparam logic [OP_W-1:0] OP_X0    = 5'd13;  // swap: read root
	localparam logic [OP_W-1:0] OP_X1    = 5'd14;  // swap: read end
	localparam logic [OP_W-1:0] OP_X2    = 5'd15;  // swap: write root
	localparam logic [OP_W-1:0] OP_X3    = 5'd16;  // swap: write end, shrink heap
	localparam logic [OP_W-1:0] OP_DONE  = 5'd17;  // push sort result

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            root;   // sift starts at the root (extraction phase)
	} ctl_cmd_t;

	typedef struct packed {
		logic too_few;   // fewer than two entries to sort
		logic l_out;     // left child beyond heap
		logic r_in;      // right child inside heap
		logic move;      // larger child beats sifted value
		logic par_zero;  // build phase at the root
		logic lim_one;   // last swap of extraction
	} dp_sts_t;

	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] data;
	} res_t;

endpackage

// File: rtl/hse_outq.sv
// ----------------------------------------------------------------------------
// hse_outq: two-entry result queue
// Decouples the result stream from the engine so a new transaction can be
// taken while an earlier result is still waiting.
// ----------------------------------------------------------------------------
module hse_outq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  hse_pkg::res_t push_res,
	output logic          room,
	output logic          out_valid,
	input  logic          out_ready,
	output hse_pkg::res_t out_res
);
	import hse_pkg::*;

	res_t       ent_q [2];
	logic       head_q;
	logic [1:0] cnt_q;
	logic       pop;
	logic       tail;

	assign pop       = out_valid & out_ready;
	assign out_valid = (cnt_q != 2'd0);
	assign room      = (cnt_q != 2'd2);
	assign out_res   = ent_q[head_q];
	assign tail      = head_q ^ cnt_q[0];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[tail] <= push_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (pop) begin
				head_q <= ~head_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q != 2'd2))
		else $error("result pushed into full queue");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result queue count out of range");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> (cnt_q == $past(cnt_q) - 2'd1))
		else $error("result queue count not decremented on pop");

endmodule

// File: rtl/hse_dp.sv
// ----------------------------------------------------------------------------
// hse_dp: heap sort datapath
// Entry memory (one write, one registered read per cycle), sift registers,
// heap bounds and the active count register.
// ----------------------------------------------------------------------------
module hse_dp #(
	parameter int DEPTH       = 1024,
	parameter int VALUE_WIDTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [hse_pkg::CNT_W-1:0]   cfg_wdata,
	input  hse_pkg::ctl_cmd_t           ctl,
	input  logic [hse_pkg::IDX_W-1:0]   index,
	input  logic [hse_pkg::DATA_W-1:0]  value,
	output hse_pkg::dp_sts_t            sts,
	output logic                        res_push,
	output hse_pkg::res_t               res
);
	import hse_pkg::*;

	localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
	localparam int NW = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;
	localparam int CW = AW + 2;

	logic [CNT_W-1:0]       count_q;
	logic [VALUE_WIDTH-1:0] mem [DEPTH];
	logic [VALUE_WIDTH-1:0] rd_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [VALUE_WIDTH-1:0] bval_q;
	logic [AW-1:0]          cur_q;
	logic [AW-1:0]          big_q;
	logic [AW-1:0]          lim_q;
	logic [AW-1:0]          par_q;
	logic                   rd_ok_q;

	logic [NW-1:0]          n_ext;
	logic [NW-1:0]          n_sat;
	logic [CW-1:0]          l_w;
	logic [CW-1:0]          r_w;
	logic [CW-1:0]          lim_w;
	logic [31:0]            idx32;
	logic [31:0]            val32;
	logic [31:0]            rd32;
	logic                   idx_ok;
	logic [AW-1:0]          idx_a;

	logic                   mem_we;
	logic                   mem_re;
	logic [AW-1:0]          wa;
	logic [AW-1:0]          ra;
	logic [VALUE_WIDTH-1:0] wd;

	// active count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_RESET;
		end else if (cfg_we) begin
			count_q <= cfg_wdata;
		end
	end

	// saturate count at store size
	assign n_ext = NW'(count_q);
	assign n_sat = (n_ext > NW'(DEPTH)) ? NW'(DEPTH) : n_ext;

	// children of the current node
	assign l_w   = CW'({cur_q, 1'b1});
	assign r_w   = CW'({cur_q, 1'b0}) + CW'(2);
	assign lim_w = CW'(lim_q);

	assign idx32  = 32'(index);
	assign val32  = 32'(value);
	assign rd32   = 32'(rd_q);
	assign idx_ok = (idx32 < 32'(DEPTH));
	assign idx_a  = idx32[AW-1:0];

	assign sts.too_few  = (n_sat < NW'(2));
	assign sts.l_out    = (l_w > lim_w);
	assign sts.r_in     = (r_w <= lim_w);
	assign sts.move     = (big_q != cur_q);
	assign sts.par_zero = (par_q == '0);
	assign sts.lim_one  = (lim_q == AW'(1));

	always_comb begin
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		wa       = '0;
		ra       = '0;
		wd       = val_q;
		res_push = 1'b0;
		res.data = '0;
		res.done = 1'b0;
		case (ctl.op)
			OP_WR: begin
				mem_we   = idx_ok;
				wa       = idx_a;
				wd       = val32[VALUE_WIDTH-1:0];
				res_push = 1'b1;
			end
			OP_NOP: begin
				res_push = 1'b1;
			end
			OP_RD: begin
				mem_re = idx_ok;
				ra     = idx_a;
			end
			OP_RDRES: begin
				res_push = 1'b1;
				res.data = rd_ok_q ? rd32[DATA_W-1:0] : '0;
			end
			OP_BEGIN: begin
				mem_re = 1'b1;
				ra     = ctl.root ? '0 : par_q;
			end
			OP_CHK: begin
				if (sts.l_out) begin
					// leaf reached: drop sifted value into the hole
					mem_we = 1'b1;
					wa     = cur_q;
				end else begin
					mem_re = 1'b1;
					ra     = l_w[AW-1:0];
				end
			end
			OP_CMPL: begin
				mem_re = sts.r_in;
				ra     = r_w[AW-1:0];
			end
			OP_DEC: begin
				mem_we = 1'b1;
				wa     = cur_q;
				wd     = sts.move ? bval_q : val_q;
			end
			OP_X0: begin
				mem_re = 1'b1;
			end
			OP_X1: begin
				mem_re = 1'b1;
				ra     = lim_q;
			end
			OP_X2: begin
				mem_we = 1'b1;
				wd     = rd_q;
			end
			OP_X3: begin
				mem_we = 1'b1;
				wa     = lim_q;
			end
			OP_DONE: begin
				res_push = 1'b1;
				res.done = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// entry memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wa] <= wd;
		end
		if (mem_re) begin
			rd_q <= mem[ra];
		end
	end

	// sift registers
	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_RD: begin
				rd_ok_q <= idx_ok;
			end
			OP_INIT: begin
				lim_q <= AW'(n_sat - NW'(1));
				par_q <= AW'((n_sat - NW'(2)) >> 1);
			end
			OP_BEGIN: begin
				cur_q <= ctl.root ? '0 : par_q;
			end
			OP_LOAD: begin
				val_q <= rd_q;
			end
			OP_CMPL: begin
				if (val_q < rd_q) begin
					big_q  <= l_w[AW-1:0];
					bval_q <= rd_q;
				end else begin
					big_q  <= cur_q;
					bval_q <= val_q;
				end
			end
			OP_CMPR: begin
				if (bval_q < rd_q) begin
					big_q  <= r_w[AW-1:0];
					bval_q <= rd_q;
				end
			end
			OP_DEC: begin
				if (sts.move) begin
					cur_q <= big_q;
				end
			end
			OP_PDEC: begin
				par_q <= par_q - AW'(1);
			end
			OP_X1: begin
				val_q <= rd_q;
			end
			OP_X3: begin
				lim_q <= lim_q - AW'(1);
			end
			default: begin
			end
		endcase
	end

endmodule

// File: rtl/hse_ctrl.sv
// ----------------------------------------------------------------------------
// hse_ctrl: heap sort controller
// Decodes host commands and sequences heap build, sift-down and swap steps
// as datapath operations.
// ----------------------------------------------------------------------------
module hse_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [hse_pkg::CMD_W-1:0] cmd,
	input  logic                      room,
	input  hse_pkg::dp_sts_t          sts,
	output logic                      in_ready,
	output hse_pkg::ctl_cmd_t         ctl
);
	import hse_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_RD    = 4'd1;
	localparam logic [3:0] ST_INIT  = 4'd2;
	localparam logic [3:0] ST_BEGIN = 4'd3;
	localparam logic [3:0] ST_LOAD  = 4'd4;
	localparam logic [3:0] ST_CHK   = 4'd5;
	localparam logic [3:0] ST_CMPL  = 4'd6;
	localparam logic [3:0] ST_CMPR  = 4'd7;
	localparam logic [3:0] ST_DEC   = 4'd8;
	localparam logic [3:0] ST_NEXT  = 4'd9;
	localparam logic [3:0] ST_X0    = 4'd10;
	localparam logic [3:0] ST_X1    = 4'd11;
	localparam logic [3:0] ST_X2    = 4'd12;
	localparam logic [3:0] ST_X3    = 4'd13;
	localparam logic [3:0] ST_DONE  = 4'd14;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       phase_q;   // 0 heap build, 1 extraction
	logic       phase_d;
	logic       in_fire;

	assign in_ready = (state_q == ST_IDLE) && room;
	assign in_fire  = in_valid && in_ready;

	always_comb begin
		state_d  = state_q;
		phase_d  = phase_q;
		ctl.op   = OP_IDLE;
		ctl.root = phase_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					case (cmd)
						CMD_WRITE: ctl.op = OP_WR;
						CMD_READ: begin
							ctl.op  = OP_RD;
							state_d = ST_RD;
						end
						CMD_SORT: state_d = ST_INIT;
						default:  ctl.op = OP_NOP;
					endcase
				end
			end
			ST_RD: begin
				ctl.op  = OP_RDRES;
				state_d = ST_IDLE;
			end
			ST_INIT: begin
				ctl.op  = OP_INIT;
				phase_d = 1'b0;
				state_d = sts.too_few ? ST_DONE : ST_BEGIN;
			end
			ST_BEGIN: begin
				ctl.op  = OP_BEGIN;
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				ctl.op  = OP_LOAD;
				state_d = ST_CHK;
			end
			ST_CHK: begin
				ctl.op  = OP_CHK;
				state_d = sts.l_out ? ST_NEXT : ST_CMPL;
			end
			ST_CMPL: begin
				ctl.op  = OP_CMPL;
				state_d = sts.r_in ? ST_CMPR : ST_DEC;
			end
			ST_CMPR: begin
				ctl.op  = OP_CMPR;
				state_d = ST_DEC;
			end
			ST_DEC: begin
				ctl.op  = OP_DEC;
				state_d = sts.move ? ST_CHK : ST_NEXT;
			end
			ST_NEXT: begin
				if (phase_q) begin
					state_d = ST_X0;
				end else begin
					state_d = ST_BEGIN;
					if (sts.par_zero) begin
						phase_d = 1'b1;
					end else begin
						ctl.op = OP_PDEC;
					end
				end
			end
			ST_X0: begin
				ctl.op  = OP_X0;
				state_d = ST_X1;
			end
			ST_X1: begin
				ctl.op  = OP_X1;
				state_d = ST_X2;
			end
			ST_X2: begin
				ctl.op  = OP_X2;
				state_d = ST_X3;
			end
			ST_X3: begin
				ctl.op  = OP_X3;
				state_d = sts.lim_one ? ST_DONE : ST_BEGIN;
			end
			ST_DONE: begin
				ctl.op  = OP_DONE;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

	a_sort_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && cmd == CMD_SORT) |=> (state_q == ST_INIT))
		else $error("sort transaction did not start heap build");

	a_swap_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_X0) |-> phase_q)
		else $error("root swap outside extraction phase");

	a_short_sort: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INIT && sts.too_few) |=> (state_q == ST_DONE))
		else $error("short sort did not finish at once");

endmodule

// File: rtl/heap_sort_engine.sv
// ----------------------------------------------------------------------------
// heap_sort_engine: in-place max-heap sort over an entry store
// Top level: stream ports, config register port, controller, datapath and
// result queue.
// ----------------------------------------------------------------------------
// Usage
//   Slave stream (s_*) carries one command per transaction: write an entry,
//   read an entry, or sort entries 0..active_count-1 ascending in place.
//   Master stream (m_*) returns exactly one result per command, in order:
//   read data for a read (zero for an index beyond the store), m_tuser set
//   for the answer to a sort, all zero otherwise.
//   cfg_we/cfg_wdata load active_count; write it only while the engine is
//   idle. Counts above DEPTH act as DEPTH.
// Timing
//   Write: one per clock while the result queue has room; the result is
//   pushed into the result queue in the cycle the command is accepted.
//   Read: the registered memory read is issued on acceptance and its result
//   is pushed from the read state; no command is taken in between.
//   Sort: the single memory port pair sets the pace of each sift level.
//   Reset clears control state and sets active_count to 1024; entry contents
//   are undefined until written. A two-entry result queue absorbs a stalled
//   receiver; commands are held off while the engine is busy or both are full.
// ----------------------------------------------------------------------------
module heap_sort_engine #(
	parameter int DEPTH       = 1024,
	parameter int VALUE_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// command stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [hse_pkg::S_TDATA_W-1:0]  s_tdata,   // cmd[1:0], index[11:2], value[27:12]
	// result stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [hse_pkg::M_TDATA_W-1:0]  m_tdata,   // read_data[15:0]
	output logic                           m_tuser,   // sort_done[0]
	// configuration
	input  logic                           cfg_we,
	input  logic [hse_pkg::CNT_W-1:0]      cfg_wdata  // active_count
);
	import hse_pkg::*;

	logic [CMD_W-1:0]  cmd;
	logic [IDX_W-1:0]  index;
	logic [DATA_W-1:0] value;

	ctl_cmd_t          ctl;
	dp_sts_t           sts;
	logic              room;
	logic              res_push;
	res_t              res;
	res_t              out_res;

	// unpack the command transaction
	assign cmd   = s_tdata[CMD_W-1:0];
	assign index = s_tdata[CMD_W +: IDX_W];
	assign value = s_tdata[CMD_W + IDX_W +: DATA_W];

	hse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.cmd      (cmd),
		.room     (room),
		.sts      (sts),
		.in_ready (s_tready),
		.ctl      (ctl)
	);

	hse_dp #(
		.DEPTH       (DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.ctl       (ctl),
		.index     (index),
		.value     (value),
		.sts       (sts),
		.res_push  (res_push),
		.res       (res)
	);

	// results wait here so a stalled receiver does not freeze the engine
	hse_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_res  (res),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = out_res.data;
	assign m_tuser = out_res.done;

endmodule

// File: tb/sv/hse_check_pkg.sv
// ----------------------------------------------------------------------------
// hse_check_pkg: result tracking for the heap sort engine bench
// Mirrors the entry store and active_count, predicts one result per
// command and checks the result stream in order.
// ----------------------------------------------------------------------------
package hse_check_pkg;

	import hse_pkg::*;

	localparam int STORE_DEPTH = 1024;

	// cmd code with no defined action, still answered with an empty result
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	class heap_store_tracker;

		bit [DATA_W-1:0] entries [STORE_DEPTH];
		int unsigned     ordered_len = STORE_DEPTH;
		res_t            pending_results [$];
		int unsigned     failures = 0;

		function void set_count(bit [CNT_W-1:0] count);
			ordered_len = (count > STORE_DEPTH) ? STORE_DEPTH : count;
		endfunction

		function void swap_entries(int unsigned a, int unsigned b);
			bit [DATA_W-1:0] t;
			t = entries[a];
			entries[a] = entries[b];
			entries[b] = t;
		endfunction

		// push entries[node] down until it dominates its children in 0..tail
		function void sift(int unsigned node, int unsigned tail);
			int unsigned cur, lc, rc, larger;
			bit settled;
			cur = node;
			settled = 0;
			while (!settled) begin
				lc = 2 * cur + 1;
				rc = 2 * cur + 2;
				larger = cur;
				if (lc <= tail && entries[larger] < entries[lc])
					larger = lc;
				if (rc <= tail && entries[larger] < entries[rc])
					larger = rc;
				if (lc > tail || larger == cur) begin
					settled = 1;
				end else begin
					swap_entries(cur, larger);
					cur = larger;
				end
			end
		endfunction

		function void heapsort_entries();
			int p;
			int unsigned tail, e;
			if (ordered_len < 2)
				return;
			tail = ordered_len - 1;
			for (p = (tail - 1) / 2; p >= 0; p--)
				sift(p, tail);
			for (e = tail; e > 0; e--) begin
				sift(0, e);
				swap_entries(0, e);
			end
		endfunction

		function void accept_command(bit [CMD_W-1:0] cmd, bit [IDX_W-1:0] idx,
				bit [DATA_W-1:0] val);
			res_t r;
			r = '0;
			case (cmd)
				CMD_WRITE: entries[idx] = val;
				CMD_READ:  r.data = entries[idx];
				CMD_SORT: begin
					heapsort_entries();
					r.done = 1'b1;
				end
				default: ;
			endcase
			pending_results.push_back(r);
		endfunction

		function void check_result(logic [DATA_W-1:0] data, logic done);
			res_t exp_r;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result data=%h done=%b", $time, data, done);
				failures++;
				return;
			end
			exp_r = pending_results.pop_front();
			if (data !== exp_r.data) begin
				$display("%0t: read_data mismatch: expected %h, actual %h",
					$time, exp_r.data, data);
				failures++;
			end
			if (done !== exp_r.done) begin
				$display("%0t: sort_done mismatch: expected %b, actual %b",
					$time, exp_r.done, done);
				failures++;
			end
		endfunction

		function int unsigned outstanding();
			return pending_results.size();
		endfunction

	endclass

endpackage

// File: tb/sv/tb_heap_sort_engine.sv
// ----------------------------------------------------------------------------
// tb_heap_sort_engine: self-checking regression for the heap sort engine
// Directed writes, reads, unused commands and sorts at the count extremes,
// a back-to-back fill with a sort, then random write/sort/read-back rounds
// of varying size. Both streams idle at random; results are checked in
// order against a tracked copy of the entry store.
// ----------------------------------------------------------------------------
module tb_heap_sort_engine;

	import hse_pkg::*;
	import hse_check_pkg::*;

	// slowest legit quiet period is a 300-entry sort
	localparam int unsigned STALL_LIMIT = 250000;
	localparam int unsigned RANDOM_TARGET = 280;
	// entries loaded by the back-to-back fill
	localparam int unsigned FILL_LEN = 64;
	// one long receiver hold-off, placed early in the back-to-back fill
	localparam int unsigned HOLD_AFTER = 40;
	localparam int unsigned LONG_HOLD = 400;
	localparam int unsigned DRAIN_SETTLE = 4;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;   // cmd[1:0], index[11:2], value[27:12]
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_TDATA_W-1:0]  m_tdata;   // read_data[15:0]
	logic                  m_tuser;   // sort_done[0]
	logic                  cfg_we;
	logic [CNT_W-1:0]      cfg_wdata; // active_count

	heap_store_tracker tracker;
	bit gaps_on;

	heap_sort_engine u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #1 clk = ~clk;

	// Offer one command transaction; valid stays high on return so that a
	// zero gap gives back-to-back transactions.
	task automatic send_cmd(bit [CMD_W-1:0] cmd, bit [IDX_W-1:0] idx,
			bit [DATA_W-1:0] val);
		int unsigned gap;
		gap = gaps_on ? $urandom_range(0, 14) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0, val, idx, cmd};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		tracker.accept_command(cmd, idx, val);
	endtask

	task automatic stop_sending();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	// sender side pause: nothing moves until every expected result is back
	task automatic wait_drained();
		while (tracker.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_SETTLE) @(posedge clk);
	endtask

	// register writes only with the engine idle
	task automatic set_active_count(bit [CNT_W-1:0] count);
		stop_sending();
		wait_drained();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= count;
		tracker.set_count(count);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Result side: random tready gaps, one long hold-off so the two-entry
	// result queue fills and s_tready drops while commands keep coming.
	// ------------------------------------------------------------------
	initial begin : result_sink
		int unsigned gap;
		int unsigned seen;
		bit held;
		m_tready = 1'b0;
		seen = 0;
		held = 0;
		@(posedge arst_n);
		forever begin
			gap = gaps_on ? $urandom_range(0, 14) : 0;
			if (!held && seen == HOLD_AFTER) begin
				gap = LONG_HOLD;
				held = 1;
			end
			@(negedge clk);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			tracker.check_result(m_tdata, m_tuser);
			seen++;
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: too long without any transaction on either stream.
	// ------------------------------------------------------------------
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("heap_sort_engine regression: fail");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin : stimulus
		int unsigned n, r, mode, picks, random_sent, i;
		bit [DATA_W-1:0] v;

		tracker   = new;
		clk       = 1'b0;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		gaps_on   = 1'b1;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// --- directed ---------------------------------------------------
		// reset count is 1024 over an unwritten store; shrink before sorting
		set_active_count(11'd8);
		// value extremes and duplicates in the first eight entries
		send_cmd(CMD_WRITE, 10'd0, 16'hFFFF);
		send_cmd(CMD_WRITE, 10'd1, 16'h0000);
		send_cmd(CMD_WRITE, 10'd2, 16'h8000);
		send_cmd(CMD_WRITE, 10'd3, 16'h7FFF);
		send_cmd(CMD_WRITE, 10'd4, 16'h0001);
		send_cmd(CMD_WRITE, 10'd5, 16'hFFFF);
		send_cmd(CMD_WRITE, 10'd6, 16'h1234);
		send_cmd(CMD_WRITE, 10'd7, 16'h0000);
		// top index, read back, unused command
		send_cmd(CMD_WRITE, 10'd1023, 16'hA5A5);
		send_cmd(CMD_READ, 10'd1023, 16'hFFFF);
		send_cmd(CMD_READ, 10'd0, 16'h0000);
		send_cmd(CMD_UNUSED, 10'd1023, 16'hFFFF);
		send_cmd(CMD_SORT, 10'd0, 16'h0000);
		for (i = 0; i < 8; i++)
			send_cmd(CMD_READ, IDX_W'(i), 16'h0000);
		// empty and single-entry sorts still report done
		set_active_count(11'd0);
		send_cmd(CMD_SORT, 10'd0, 16'h0000);
		set_active_count(11'd1);
		send_cmd(CMD_SORT, 10'd0, 16'h0000);
		set_active_count(11'd2);
		send_cmd(CMD_WRITE, 10'd0, 16'hFFFF);
		send_cmd(CMD_SORT, 10'd0, 16'h0000);
		send_cmd(CMD_READ, 10'd1, 16'h0000);

		// --- back-to-back fill --------------------------------------------
		// no idling on either side; the receiver's long hold lands here
		gaps_on = 1'b0;
		for (i = 0; i < FILL_LEN; i++)
			send_cmd(CMD_WRITE, IDX_W'(i), DATA_W'($urandom_range(0, 65535)));
		gaps_on = 1'b1;
		set_active_count(CNT_W'(FILL_LEN));
		send_cmd(CMD_SORT, 10'd0, 16'h0000);
		for (i = 0; i < 16; i++)
			send_cmd(CMD_READ, IDX_W'($urandom_range(0, FILL_LEN - 1)), 16'h0000);
		send_cmd(CMD_READ, 10'd0, 16'h0000);
		send_cmd(CMD_READ, IDX_W'(FILL_LEN - 1), 16'h0000);
		// same count over already-sorted data
		send_cmd(CMD_SORT, 10'd0, 16'h0000);
		send_cmd(CMD_READ, IDX_W'(FILL_LEN / 2), 16'h0000);

		// --- random rounds ------------------------------------------------
		// entries 0..FILL_LEN-1 and the top entry are written by now
		random_sent = 0;
		while (random_sent < RANDOM_TARGET) begin
			r = $urandom_range(0, 19);
			case (r)
				0:       n = 0;
				1:       n = 1;
				2:       n = $urandom_range(121, 300);
				3, 4:    n = $urandom_range(25, 120);
				default: n = $urandom_range(2, 24);
			endcase
			set_active_count(CNT_W'(n));
			gaps_on = ($urandom_range(0, 3) != 0);
			mode = $urandom_range(0, 3);

			// well-formed round: load 0..n-1, sprinkle noise, sort, read back
			for (i = 0; i < n; i++) begin
				case (mode)
					0: v = DATA_W'($urandom_range(0, 65535));
					1: v = DATA_W'($urandom_range(0, 7));     // heavy duplicates
					2: v = DATA_W'(i * 97);                    // ascending
					default: v = DATA_W'(32'hFFFF - i * 131);  // descending
				endcase
				send_cmd(CMD_WRITE, IDX_W'(i), v);
				random_sent++;
				if ($urandom_range(0, 7) == 0) begin
					case ($urandom_range(0, 3))
						0: send_cmd(CMD_READ, IDX_W'($urandom_range(0, FILL_LEN - 1)),
							16'h0000);
						1: send_cmd(CMD_UNUSED, IDX_W'($urandom_range(0, 1023)),
							DATA_W'($urandom_range(0, 65535)));
						2: send_cmd(CMD_WRITE, IDX_W'($urandom_range(n, 1023)),
							DATA_W'($urandom_range(0, 65535)));
						default: send_cmd(CMD_READ, IDX_W'($urandom_range(0, i)),
							16'h0000);
					endcase
					random_sent++;
				end
			end
			send_cmd(CMD_SORT, IDX_W'($urandom_range(0, 1023)),
				DATA_W'($urandom_range(0, 65535)));
			random_sent++;

			// short rounds are read back whole, long ones sampled
			picks = (n <= 24) ? n : 12;
			for (i = 0; i < picks; i++) begin
				send_cmd(CMD_READ, IDX_W'((n <= 24) ? i : $urandom_range(0, n - 1)),
					DATA_W'($urandom_range(0, 65535)));
				random_sent++;
			end
		end

		stop_sending();
		wait_drained();
		repeat (20) @(posedge clk);
		if (tracker.failures == 0 && tracker.outstanding() == 0)
			$display("heap_sort_engine regression: pass");
		else
			$display("heap_sort_engine regression: fail");
		$finish;
	end

endmodule
